/* rtl/dhcm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the diverging heat-map color map.
// No dependencies; imported by dhcm_front, dhcm_back and the top level.
package dhcm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int SPAN_W   = 33;   // max - min of two signed 32-bit values
	localparam int MULT_W   = 36;   // up to 5 * span
	localparam int NUM_W    = 40;   // palette blend, below 100 * span
	localparam int IDX_W    = 4;
	localparam int PAL_W    = 7;
	localparam int PAL_N    = 12;   // 11 entries plus a zero pad above the last
	localparam int CH_N     = 3;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [IDX_W-1:0] FIRST_ENTRY = 4'd0;
	localparam logic [IDX_W-1:0] LAST_ENTRY  = 4'd10;
	localparam logic [IDX_W-1:0] LOWER_BASE  = 4'd5;

	localparam logic [1:0] REG_MIN  = 2'd0;
	localparam logic [1:0] REG_MEAN = 2'd1;
	localparam logic [1:0] REG_MAX  = 2'd2;

	typedef enum logic [1:0] {
		CLS_TOP,
		CLS_UPPER,
		CLS_LOWER,
		CLS_BOTTOM
	} cls_t;

	// Work item between front and back: blend P[idx]*a + P[idx+1]*(span-a)
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [SPAN_W-1:0] a;
		logic [SPAN_W-1:0] span;
	} blend_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} color_t;

	// Palette in hundredths: red, green, blue
	localparam logic [PAL_W-1:0] PAL [CH_N][PAL_N] = '{
		'{7'd33, 7'd55, 7'd75, 7'd87, 7'd96, 7'd99, 7'd78, 7'd50, 7'd21, 7'd0, 7'd0, 7'd0},
		'{7'd19, 7'd32, 7'd51, 7'd76, 7'd91, 7'd96, 7'd92, 7'd80, 7'd59, 7'd40, 7'd24, 7'd0},
		'{7'd2,  7'd4,  7'd18, 7'd49, 7'd76, 7'd89, 7'd90, 7'd76, 7'd56, 7'd37, 7'd19, 7'd0}
	};

endpackage

/* rtl/dhcm_if.sv */
`timescale 1ns / 1ps
// Channel interfaces: density sample in, RGB color out.
// Depends on nothing.
interface dhcm_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] density_sample;
	modport source(output valid, output density_sample, input ready);
	modport sink(input valid, input density_sample, output ready);
endinterface

interface dhcm_color_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_level;
	logic [7:0] green_level;
	logic [7:0] blue_level;
	modport source(output valid, output red_level, output green_level, output blue_level,
		input ready);
	modport sink(input valid, input red_level, input green_level, input blue_level,
		output ready);
endinterface

/* rtl/dhcm_fifo.sv */
`timescale 1ns / 1ps
// Small register FIFO; callers guarantee no push when full (credit counted).
// Depends on nothing.
module dhcm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             rvalid,
	output logic [WIDTH-1:0] rdata
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rvalid = count_q != '0;
	assign rdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (!push && pop) count_q <= count_q - 1'b1;
		end
	end
endmodule

/* rtl/dhcm_front.sv */
`timescale 1ns / 1ps
// Front end: accepts samples, classifies them against min/mean/max and finds
// band and blend weight. Depends on dhcm_pkg and dhcm_sample_if.
module dhcm_front import dhcm_pkg::*; #(
	parameter int Q_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	dhcm_sample_if.sink        smp,
	input  logic signed [31:0] dmin,
	input  logic signed [31:0] dmean,
	input  logic signed [31:0] dmax,
	output logic               q_push,
	output blend_t             q_data,
	input  logic               q_pop
);
	localparam int PEND_W = $clog2(Q_DEPTH + 1);

	logic [PEND_W-1:0] pend_q;
	logic              fire;

	// Credit: items in the stages plus items in the queue never exceed its depth
	assign smp.ready = pend_q < PEND_W'(Q_DEPTH);
	assign fire      = smp.valid && smp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (fire && !q_pop) begin
			pend_q <= pend_q + 1'b1;
		end else if (!fire && q_pop) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// Stage 1: classify
	cls_t               cls_c;
	logic signed [31:0] top_c, low_c;

	always_comb begin
		if (smp.density_sample > dmax)       cls_c = CLS_TOP;
		else if (smp.density_sample > dmean) cls_c = CLS_UPPER;
		else if (smp.density_sample > dmin)  cls_c = CLS_LOWER;
		else                                 cls_c = CLS_BOTTOM;
		top_c = (cls_c == CLS_UPPER) ? dmax : dmean;
		low_c = (cls_c == CLS_UPPER) ? dmean : dmin;
	end

	logic               v_s1, v_s2, v_s3, v_s4;
	cls_t               cls_s1, cls_s2, cls_s3, cls_s4;
	logic signed [31:0] x_s1, top_s1, low_s1;
	logic [SPAN_W-1:0]  span_s2, dist_s2, span_s3, span_s4;
	logic [MULT_W-1:0]  d5_s3, m3_s3, m5_s3, d5_s4, bs_s4;
	logic [2:0]         band_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cls_s1 <= cls_c;
		x_s1   <= smp.density_sample;
		top_s1 <= top_c;
		low_s1 <= low_c;
	end

	// Stage 2: span and distance from the top edge, non-negative unless CLS_TOP
	always_ff @(posedge clk) begin
		cls_s2  <= cls_s1;
		span_s2 <= {top_s1[31], top_s1} - {low_s1[31], low_s1};
		dist_s2 <= {top_s1[31], top_s1} - {x_s1[31], x_s1};
	end

	// Stage 3: 5*dist and odd multiples of span
	always_ff @(posedge clk) begin
		cls_s3  <= cls_s2;
		span_s3 <= span_s2;
		d5_s3   <= {3'b0, dist_s2} + {1'b0, dist_s2, 2'b0};
		m3_s3   <= {3'b0, span_s2} + {2'b0, span_s2, 1'b0};
		m5_s3   <= {3'b0, span_s2} + {1'b0, span_s2, 2'b0};
	end

	// Stage 4: band = floor(5*dist/span) by compare against span multiples
	logic [MULT_W-1:0] m1_c, m2_c, m4_c, bs_c;
	logic [2:0]        band_c;

	always_comb begin
		m1_c   = {3'b0, span_s3};
		m2_c   = {2'b0, span_s3, 1'b0};
		m4_c   = {1'b0, span_s3, 2'b0};
		band_c = 3'(d5_s3 >= m1_c) + 3'(d5_s3 >= m2_c) + 3'(d5_s3 >= m3_s3)
			+ 3'(d5_s3 >= m4_c);
		case (band_c)
			3'd0:    bs_c = m1_c;
			3'd1:    bs_c = m2_c;
			3'd2:    bs_c = m3_s3;
			3'd3:    bs_c = m4_c;
			default: bs_c = m5_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		cls_s4  <= cls_s3;
		span_s4 <= span_s3;
		d5_s4   <= d5_s3;
		band_s4 <= band_c;
		bs_s4   <= bs_c;
	end

	// Weight a = (band+1)*span - 5*dist lies in 1..span; entries use a = span = 1
	always_comb begin
		q_push = v_s4;
		q_data.a    = SPAN_W'(bs_s4 - d5_s4);
		q_data.span = span_s4;
		unique case (cls_s4)
			CLS_TOP: begin
				q_data.idx  = FIRST_ENTRY;
				q_data.a    = SPAN_W'(1);
				q_data.span = SPAN_W'(1);
			end
			CLS_UPPER: q_data.idx = {1'b0, band_s4};
			CLS_LOWER: q_data.idx = LOWER_BASE + {1'b0, band_s4};
			default: begin
				q_data.idx  = LAST_ENTRY;
				q_data.a    = SPAN_W'(1);
				q_data.span = SPAN_W'(1);
			end
		endcase
	end
endmodule

/* rtl/dhcm_back.sv */
`timescale 1ns / 1ps
// Back end: palette blend, scaling and a pipelined restoring divider, one
// quotient bit per stage. Depends on dhcm_pkg.
module dhcm_back import dhcm_pkg::*; #(
	parameter int COLOR_BITS = 8,
	parameter int OUT_DEPTH  = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_valid,
	input  blend_t q_data,
	output logic   q_pop,
	output logic   o_push,
	output color_t o_data,
	input  logic   o_pop
);
	localparam int PEND_W = $clog2(OUT_DEPTH + 1);
	localparam int NW     = NUM_W + 1 + COLOR_BITS;
	localparam int HW     = 40;   // 100 * span fits

	logic [PEND_W-1:0] pend_q;

	assign q_pop = q_valid && (pend_q < PEND_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (q_pop && !o_pop) begin
			pend_q <= pend_q + 1'b1;
		end else if (!q_pop && o_pop) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]  idx_s1;
	logic [SPAN_W-1:0] a_s1, sa_s1, span_s1, span_s2, span_s3;
	logic [NUM_W-1:0]  pa_s2 [CH_N];
	logic [NUM_W-1:0]  pb_s2 [CH_N];
	logic [NUM_W-1:0]  num_s3 [CH_N];
	logic [NW-1:0]     ns_s4 [CH_N];
	logic [HW-1:0]     h50_s4;

	logic [NW-1:0]         div_rem_s [COLOR_BITS+1][CH_N];
	logic [COLOR_BITS-1:0] div_quo_s [COLOR_BITS+1][CH_N];
	logic [HW-1:0]         div_den_s [COLOR_BITS+1];
	logic                  div_v_s   [COLOR_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			div_v_s[0] <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			div_v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= q_data.idx;
		a_s1    <= q_data.a;
		sa_s1   <= q_data.span - q_data.a;
		span_s1 <= q_data.span;
		span_s2 <= span_s1;
		span_s3 <= span_s2;
		h50_s4  <= (HW'(span_s3) << 5) + (HW'(span_s3) << 4) + (HW'(span_s3) << 1);
		div_den_s[0] <= h50_s4 << 1;
		for (int c = 0; c < CH_N; c++) begin
			pa_s2[c]  <= NUM_W'(PAL[c][idx_s1]) * NUM_W'(a_s1);
			pb_s2[c]  <= NUM_W'(PAL[c][idx_s1 + 1'b1]) * NUM_W'(sa_s1);
			num_s3[c] <= pa_s2[c] + pb_s2[c];
			// num * (2^COLOR_BITS - 1)
			ns_s4[c]  <= (NW'(num_s3[c]) << COLOR_BITS) - NW'(num_s3[c]);
			// + 50*span rounds half up in the division by 100*span
			div_rem_s[0][c] <= ns_s4[c] + NW'(h50_s4);
			div_quo_s[0][c] <= '0;
		end
	end

	for (genvar j = 1; j <= COLOR_BITS; j++) begin : g_div
		logic [NW-1:0] sh;
		assign sh = NW'(div_den_s[j-1]) << (COLOR_BITS - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j] <= 1'b0;
			end else begin
				div_v_s[j] <= div_v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			div_den_s[j] <= div_den_s[j-1];
			for (int c = 0; c < CH_N; c++) begin
				if (div_rem_s[j-1][c] >= sh) begin
					div_rem_s[j][c] <= div_rem_s[j-1][c] - sh;
					div_quo_s[j][c] <= {div_quo_s[j-1][c][COLOR_BITS-2:0], 1'b1};
				end else begin
					div_rem_s[j][c] <= div_rem_s[j-1][c];
					div_quo_s[j][c] <= {div_quo_s[j-1][c][COLOR_BITS-2:0], 1'b0};
				end
			end
		end
	end

	assign o_push       = div_v_s[COLOR_BITS];
	assign o_data.red   = 8'(div_quo_s[COLOR_BITS][0]);
	assign o_data.green = 8'(div_quo_s[COLOR_BITS][1]);
	assign o_data.blue  = 8'(div_quo_s[COLOR_BITS][2]);
endmodule

/* rtl/diverging_heatmap_color_map_core.sv */
`timescale 1ns / 1ps
// Top level of the diverging heat-map color map: APB registers, front end,
// work queue, back end and output queue. Depends on dhcm_pkg, dhcm_if,
// dhcm_fifo, dhcm_front and dhcm_back.
//
//  channel  dir  handshake            payload
//  smp      in   valid/ready          density_sample (s32 Q16.16)
//  pix      out  valid/ready          red_level, green_level, blue_level (u8)
//  apb      in   psel/penable/pready  min, mean, max at 0x0, 0x4, 0x8
//
// One sample per cycle sustained while pix.ready is held high. The path runs
// through 4 front stages, the work queue, 5 blend stages, one divider stage
// per color bit and the output queue. Output stalls fill the output queue,
// then the work queue, then drop smp.ready; both sides run on credits.
// Reset clears the registers to 0 and empties both queues.
module diverging_heatmap_color_map_core import dhcm_pkg::*; #(
	parameter int COLOR_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dhcm_sample_if.sink           smp,
	dhcm_color_if.source          pix,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	localparam int Q_DEPTH   = 8;
	localparam int OUT_DEPTH = 2 ** $clog2(COLOR_BITS + 7);

	logic signed [31:0] dmin_q, dmean_q, dmax_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmin_q  <= '0;
			dmean_q <= '0;
			dmax_q  <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_MIN:  dmin_q  <= pwdata;
				REG_MEAN: dmean_q <= pwdata;
				REG_MAX:  dmax_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_MIN:  prdata = dmin_q;
			REG_MEAN: prdata = dmean_q;
			REG_MAX:  prdata = dmax_q;
			default:  prdata = '0;
		endcase
	end

	logic   wq_push, wq_pop, wq_valid;
	blend_t wq_wdata, wq_rdata;
	logic   oq_push, oq_pop, oq_valid;
	color_t oq_wdata, oq_rdata;

	dhcm_front #(.Q_DEPTH(Q_DEPTH)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.dmin   (dmin_q),
		.dmean  (dmean_q),
		.dmax   (dmax_q),
		.q_push (wq_push),
		.q_data (wq_wdata),
		.q_pop  (wq_pop)
	);

	dhcm_fifo #(.WIDTH($bits(blend_t)), .DEPTH(Q_DEPTH)) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (wq_push),
		.wdata  (wq_wdata),
		.pop    (wq_pop),
		.rvalid (wq_valid),
		.rdata  (wq_rdata)
	);

	dhcm_back #(.COLOR_BITS(COLOR_BITS), .OUT_DEPTH(OUT_DEPTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (wq_valid),
		.q_data  (wq_rdata),
		.q_pop   (wq_pop),
		.o_push  (oq_push),
		.o_data  (oq_wdata),
		.o_pop   (oq_pop)
	);

	dhcm_fifo #(.WIDTH($bits(color_t)), .DEPTH(OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.wdata  (oq_wdata),
		.pop    (oq_pop),
		.rvalid (oq_valid),
		.rdata  (oq_rdata)
	);

	assign oq_pop          = oq_valid && pix.ready;
	assign pix.valid       = oq_valid;
	assign pix.red_level   = oq_rdata.red;
	assign pix.green_level = oq_rdata.green;
	assign pix.blue_level  = oq_rdata.blue;
endmodule
